/* design/rc4_pkg.sv */
// rc4_pkg: shared types and constants for the rc4 stream cipher block
// used by rc4_box_ram, rc4_key_ram and rc4_stream_cipher; no dependencies
`default_nettype none

package rc4_pkg;

  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);
  localparam int BOX_SIZE  = 256;
  localparam int BOX_AW    = $clog2(BOX_SIZE);

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_DATA = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_RJ,
    ST_D_SW,
    ST_D_ST,
    ST_D_KS,
    ST_K_RD,
    ST_K_J,
    ST_K_SW,
    ST_K_W2
  } state_e;

  typedef struct packed {
    logic              clr;
    logic              re;
    logic [BOX_AW-1:0] raddr;
    logic              we;
    logic [BOX_AW-1:0] waddr;
    logic [7:0]        wdata;
  } box_req_t;

  typedef struct packed {
    logic              re;
    logic [KEY_AW-1:0] raddr;
    logic              we;
    logic [KEY_AW-1:0] waddr;
    logic [7:0]        wdata;
  } key_req_t;

endpackage

`default_nettype wire

/* design/rc4_box_ram.sv */
// rc4_box_ram: 256 x 8 permutation box, one write and one registered read port
// per-entry valid bits make an unwritten entry read as its own index; uses rc4_pkg
`default_nettype none

module rc4_box_ram (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rc4_pkg::box_req_t req_i,
  output logic [7:0]             rdata_o
);

  logic [7:0]                  mem [rc4_pkg::BOX_SIZE];
  logic [rc4_pkg::BOX_SIZE-1:0] valid_q;
  logic [7:0]                  rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // clear brings the whole box back to identity by dropping every valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.raddr] ? mem[req_i.raddr] : 8'(req_i.raddr);
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/rc4_key_ram.sv */
// rc4_key_ram: key store, one write and one registered read port
// contents are undefined until written; uses rc4_pkg
`default_nettype none

module rc4_key_ram (
  input  wire logic              clk_i,
  input  wire rc4_pkg::key_req_t req_i,
  output logic [7:0]             rdata_o
);

  logic [7:0] mem [rc4_pkg::KEY_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/rc4_stream_cipher.sv */
// rc4_stream_cipher: rc4 engine top level with sequencer and shared 8-bit adder
// depends on rc4_pkg, rc4_box_ram and rc4_key_ram
//
//   port group   dir   payload                          handshake
//   in           in    op_i, byte_value_i, key_last_i   in_valid_i / in_stall_o
//   out          out   cipher_byte_o                    out_valid_o / out_stall_i
//
// a data word is accepted in idle, then steps through D_RJ, D_SW, D_ST and D_KS on the box ports
// a key word is taken in idle; a word marked last adds the key schedule,
//   four box accesses per swap step over 256 steps
// reset gives the identity box, zero indices and an empty key
// a data word waits in D_KS while a previous result is still stalled
`default_nettype none

module rc4_stream_cipher (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       op_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       key_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      cipher_byte_o
);

  rc4_pkg::state_e   state_q, state_d;
  rc4_pkg::box_req_t box_req;
  rc4_pkg::key_req_t key_req;

  logic [7:0]                   box_rdata, key_rdata;
  logic [7:0]                   i_q, i_d, j_q, j_d;
  logic [7:0]                   si_q, si_d, sj_q, sj_d, t_q, t_d;
  logic [7:0]                   byte_q, byte_d;
  logic [rc4_pkg::KEY_CW-1:0]   kcnt_q, kcnt_d;
  logic [rc4_pkg::KEY_AW-1:0]   kidx_q, kidx_d;
  logic [rc4_pkg::KEY_CW-1:0]   kidx_inc;
  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   cipher_q, cipher_d;
  logic [7:0]                   add_a, add_b, add_c, add_sum;
  logic                         in_fire, out_free;

  rc4_box_ram u_box (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (box_req),
    .rdata_o (box_rdata)
  );

  rc4_key_ram u_key (
    .clk_i   (clk_i),
    .req_i   (key_req),
    .rdata_o (key_rdata)
  );

  assign in_stall_o = (state_q != rc4_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !(out_valid_q && out_stall_i);
  assign add_sum    = add_a + add_b + add_c;
  assign kidx_inc   = rc4_pkg::KEY_CW'(kidx_q) + rc4_pkg::KEY_CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (op_i == rc4_pkg::OP_DATA) begin
            state_d = rc4_pkg::ST_D_RJ;
          end else if (key_last_i) begin
            state_d = rc4_pkg::ST_K_RD;
          end
        end
      end
      rc4_pkg::ST_D_RJ: state_d = rc4_pkg::ST_D_SW;
      rc4_pkg::ST_D_SW: state_d = rc4_pkg::ST_D_ST;
      rc4_pkg::ST_D_ST: state_d = rc4_pkg::ST_D_KS;
      rc4_pkg::ST_D_KS: begin
        if (out_free) begin
          state_d = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_K_RD: state_d = rc4_pkg::ST_K_J;
      rc4_pkg::ST_K_J:  state_d = rc4_pkg::ST_K_SW;
      rc4_pkg::ST_K_SW: state_d = rc4_pkg::ST_K_W2;
      rc4_pkg::ST_K_W2: begin
        state_d = (i_q == 8'hFF) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K_RD;
      end
      default: state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    box_req     = '0;
    key_req     = '0;
    add_a       = '0;
    add_b       = '0;
    add_c       = '0;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    byte_d      = byte_q;
    kcnt_d      = kcnt_q;
    kidx_d      = kidx_q;
    cipher_d    = cipher_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        add_a = i_q;
        add_b = 8'd1;
        if (in_fire) begin
          if (op_i == rc4_pkg::OP_DATA) begin
            i_d           = add_sum;
            byte_d        = byte_value_i;
            box_req.re    = 1'b1;
            box_req.raddr = add_sum;
          end else begin
            if (kcnt_q < rc4_pkg::KEY_CW'(rc4_pkg::KEY_DEPTH)) begin
              key_req.we    = 1'b1;
              key_req.waddr = kcnt_q[rc4_pkg::KEY_AW-1:0];
              key_req.wdata = byte_value_i;
              kcnt_d        = kcnt_q + rc4_pkg::KEY_CW'(1);
            end
            if (key_last_i) begin
              box_req.clr = 1'b1;
              i_d         = '0;
              j_d         = '0;
              kidx_d      = '0;
            end
          end
        end
      end
      rc4_pkg::ST_D_RJ: begin
        add_a         = j_q;
        add_b         = box_rdata;
        si_d          = box_rdata;
        j_d           = add_sum;
        box_req.re    = 1'b1;
        box_req.raddr = add_sum;
      end
      rc4_pkg::ST_D_SW: begin
        sj_d          = box_rdata;
        box_req.we    = 1'b1;
        box_req.waddr = i_q;
        box_req.wdata = box_rdata;
      end
      rc4_pkg::ST_D_ST: begin
        add_a         = si_q;
        add_b         = sj_q;
        t_d           = add_sum;
        box_req.we    = 1'b1;
        box_req.waddr = j_q;
        box_req.wdata = si_q;
        box_req.re    = 1'b1;
        box_req.raddr = add_sum;
      end
      rc4_pkg::ST_D_KS: begin
        if (out_free) begin
          // a read of the entry written in the same cycle returned its old value
          cipher_d    = byte_q ^ ((t_q == j_q) ? si_q : box_rdata);
          out_valid_d = 1'b1;
        end
      end
      rc4_pkg::ST_K_RD: begin
        box_req.re    = 1'b1;
        box_req.raddr = i_q;
        key_req.re    = 1'b1;
        key_req.raddr = kidx_q;
      end
      rc4_pkg::ST_K_J: begin
        add_a         = j_q;
        add_b         = box_rdata;
        add_c         = key_rdata;
        si_d          = box_rdata;
        j_d           = add_sum;
        box_req.re    = 1'b1;
        box_req.raddr = add_sum;
      end
      rc4_pkg::ST_K_SW: begin
        box_req.we    = 1'b1;
        box_req.waddr = i_q;
        box_req.wdata = box_rdata;
      end
      rc4_pkg::ST_K_W2: begin
        add_a         = i_q;
        add_b         = 8'd1;
        box_req.we    = 1'b1;
        box_req.waddr = j_q;
        box_req.wdata = si_q;
        i_d           = add_sum;
        kidx_d        = (kidx_inc == kcnt_q) ? '0 : kidx_inc[rc4_pkg::KEY_AW-1:0];
        if (i_q == 8'hFF) begin
          i_d    = '0;
          j_d    = '0;
          kcnt_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      kcnt_q      <= '0;
      kidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      kcnt_q      <= kcnt_d;
      kidx_q      <= kidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q     <= si_d;
    sj_q     <= sj_d;
    t_q      <= t_d;
    byte_q   <= byte_d;
    cipher_q <= cipher_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = cipher_q;

  a_result_from_ks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == rc4_pkg::ST_D_KS)
    else $error("result word raised outside the keystream state");

  a_kcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kcnt_q <= rc4_pkg::KEY_CW'(rc4_pkg::KEY_DEPTH))
    else $error("key count beyond key store depth");

  a_idle_no_box_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rc4_pkg::ST_IDLE |-> !box_req.we)
    else $error("box written while idle");

  a_sched_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::ST_K_W2 && i_q == 8'hFF) |=>
      (i_q == 8'd0 && j_q == 8'd0 && kcnt_q == '0 && state_q == rc4_pkg::ST_IDLE))
    else $error("key schedule did not clear indices and key count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(cipher_q)))
    else $error("stalled result word lost or changed");

endmodule

`default_nettype wire
